>>> sv/kuf_pkg.sv
`timescale 1ns / 1ps
package kuf_pkg;

  localparam int NODE_COUNT_DEF = 256;
  localparam int RANK_W = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
  localparam int WEIGHT_W = 16;
  localparam int NODE_W = 8;
  localparam int TOTAL_W = 32;

  localparam logic FUNC_CLEAR = 1'b0;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_EDGE = 2'd1;
  localparam logic [1:0] OP_SKIP = 2'd2;

  typedef struct packed {
    logic func;
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_t;

  typedef struct packed {
    logic accepted;
    logic [TOTAL_W-1:0] total_weight;
  } out_t;

  typedef struct packed {
    logic [1:0] op;
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } fq_t;

  typedef struct packed {
    logic pop;
    logic init;
  } bk_stat_t;

endpackage

>>> sv/kuf_ram.sv
`timescale 1ns / 1ps
module kuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/kuf_front.sv
`timescale 1ns / 1ps
module kuf_front #(
  parameter int NODE_COUNT = kuf_pkg::NODE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kuf_pkg::in_t       in_data,
  input  kuf_pkg::bk_stat_t  stat,
  output kuf_pkg::fq_t       fq
);
  import kuf_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       a_ok;
  logic       b_ok;
  cmd_t       cmd_in;

  assign a_ok = int'(in_data.node_a) < NODE_COUNT;
  assign b_ok = int'(in_data.node_b) < NODE_COUNT;

  always_comb begin
    cmd_in.weight = in_data.weight;
    cmd_in.node_a = in_data.node_a;
    cmd_in.node_b = in_data.node_b;
    if (in_data.func == FUNC_CLEAR) begin
      cmd_in.op = OP_CLEAR;
    end else if (a_ok && b_ok) begin
      cmd_in.op = OP_EDGE;
    end else begin
      cmd_in.op = OP_SKIP;
    end
  end

  assign in_stall = (cnt_r == 2'd2) || stat.init;
  assign push = in_valid && !in_stall;

  assign fq.valid = cnt_r != 2'd0;
  assign fq.cmd = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (stat.pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, stat.pop})
        2'b10: cnt_r <= cnt_r + 2'd1;
        2'b01: cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> sv/kuf_back.sv
`timescale 1ns / 1ps
module kuf_back #(
  parameter int NODE_COUNT = kuf_pkg::NODE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kuf_pkg::fq_t       fq,
  output kuf_pkg::bk_stat_t  stat,
  input  logic               out_stall,
  output logic               out_valid,
  output kuf_pkg::out_t      out_data
);
  import kuf_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);
  localparam int EW = RANK_W + IW;
  localparam logic [IW-1:0] LAST_IDX = IW'(NODE_COUNT - 1);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FRD = 4'd2;
  localparam logic [3:0] S_FCHK = 4'd3;
  localparam logic [3:0] S_CRD = 4'd4;
  localparam logic [3:0] S_CCHK = 4'd5;
  localparam logic [3:0] S_JOIN = 4'd6;
  localparam logic [3:0] S_BUMP = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [3:0]          state_r;
  logic [IW-1:0]       cur_r;
  logic                side_r;
  logic                clr_cmd_r;
  logic [IW-1:0]       na_r;
  logic [IW-1:0]       nb_r;
  logic [IW-1:0]       root_a_r;
  logic [IW-1:0]       root_b_r;
  logic [RANK_W-1:0]   rk_a_r;
  logic [RANK_W-1:0]   rk_b_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [TOTAL_W-1:0]  total_r;
  logic                acc_r;
  logic                out_valid_r;
  out_t                out_data_r;

  logic                we;
  logic [IW-1:0]       waddr;
  logic [EW-1:0]       wdata;
  logic [EW-1:0]       rdata;
  logic [IW-1:0]       rd_par;
  logic [RANK_W-1:0]   rd_rank;
  logic [IW-1:0]       root_cur;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  sum_sat;
  logic [RANK_W-1:0]   rk_b_inc;

  kuf_ram #(
    .WIDTH(EW),
    .DEPTH(NODE_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cur_r),
    .rdata(rdata)
  );

  assign rd_par = rdata[IW-1:0];
  assign rd_rank = rdata[EW-1:IW];
  assign root_cur = side_r ? root_b_r : root_a_r;
  assign sum = {1'b0, total_r} + (TOTAL_W + 1)'(weight_r);
  assign sum_sat = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  assign rk_b_inc = (rk_b_r == RANK_MAX) ? rk_b_r : rk_b_r + RANK_W'(1);

  assign stat.pop = (state_r == S_IDLE) && fq.valid;
  assign stat.init = (state_r == S_INIT) && !clr_cmd_r;

  always_comb begin
    we = 1'b0;
    waddr = cur_r;
    wdata = {rd_rank, root_cur};
    unique case (state_r)
      S_INIT: begin
        we = 1'b1;
        wdata = {RANK_W'(0), cur_r};
      end
      S_CCHK: begin
        we = 1'b1;
      end
      S_JOIN: begin
        we = root_a_r != root_b_r;
        if (rk_a_r > rk_b_r) begin
          waddr = root_b_r;
          wdata = {rk_b_r, root_a_r};
        end else begin
          waddr = root_a_r;
          wdata = {rk_a_r, root_b_r};
        end
      end
      S_BUMP: begin
        we = 1'b1;
        waddr = root_b_r;
        wdata = {rk_b_inc, root_b_r};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cur_r <= '0;
      clr_cmd_r <= 1'b0;
      total_r <= '0;
      out_valid_r <= 1'b0;
      side_r <= 1'b0;
      acc_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          cur_r <= cur_r + IW'(1);
          if (cur_r == LAST_IDX) begin
            state_r <= clr_cmd_r ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (fq.valid) begin
            weight_r <= fq.cmd.weight;
            na_r <= IW'(fq.cmd.node_a);
            nb_r <= IW'(fq.cmd.node_b);
            acc_r <= 1'b0;
            side_r <= 1'b0;
            unique case (fq.cmd.op)
              OP_CLEAR: begin
                state_r <= S_INIT;
                cur_r <= '0;
                clr_cmd_r <= 1'b1;
                total_r <= '0;
              end
              OP_EDGE: begin
                state_r <= S_FRD;
                cur_r <= IW'(fq.cmd.node_a);
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_FRD: begin
          state_r <= S_FCHK;
        end
        S_FCHK: begin
          if (rd_par == cur_r) begin
            if (!side_r) begin
              root_a_r <= cur_r;
              rk_a_r <= rd_rank;
              cur_r <= na_r;
            end else begin
              root_b_r <= cur_r;
              rk_b_r <= rd_rank;
              cur_r <= nb_r;
            end
            state_r <= S_CRD;
          end else begin
            cur_r <= rd_par;
            state_r <= S_FRD;
          end
        end
        S_CRD: begin
          if (cur_r == root_cur) begin
            if (!side_r) begin
              side_r <= 1'b1;
              cur_r <= nb_r;
              state_r <= S_FRD;
            end else begin
              state_r <= S_JOIN;
            end
          end else begin
            state_r <= S_CCHK;
          end
        end
        S_CCHK: begin
          cur_r <= rd_par;
          state_r <= S_CRD;
        end
        S_JOIN: begin
          if (root_a_r == root_b_r) begin
            state_r <= S_OUT;
          end else begin
            acc_r <= 1'b1;
            total_r <= sum_sat;
            state_r <= (rk_a_r == rk_b_r) ? S_BUMP : S_OUT;
          end
        end
        S_BUMP: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r.accepted <= acc_r;
            out_data_r.total_weight <= total_r;
            clr_cmd_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

>>> sv/kruskal_union_find_edge_filter.sv
`timescale 1ns / 1ps
// Channel  Ports                         Moves
// in       in_valid, in_stall, in_data   clear command or one edge per transfer
// out      out_valid, out_stall, out_data  accept flag and tree total, one per input
//
// An edge takes, for each end node in turn, a find walk to its root and a compression
// walk that writes that root into every node on the path, then a join, and a rank bump
// when the two ranks tie; each find step reads the forest memory, which has separate
// read and write ports, and then checks the parent. A clear sweeps the forest memory.
// After reset the forest memory is swept with in_stall high.
// A two-entry queue keeps taking input, until it is full, while the back end walks or out_stall holds.
module kruskal_union_find_edge_filter #(
  parameter int NODE_COUNT = kuf_pkg::NODE_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  kuf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output kuf_pkg::out_t out_data
);
  import kuf_pkg::*;

  fq_t      fq;
  bk_stat_t stat;

  kuf_front #(
    .NODE_COUNT(NODE_COUNT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .stat    (stat),
    .fq      (fq)
  );

  kuf_back #(
    .NODE_COUNT(NODE_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .fq       (fq),
    .stat     (stat),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data)
  );

`ifndef ASSERT_OFF
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pop |-> fq.valid)
    else $error("queue popped while empty");

  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    stat.init |-> !stat.pop)
    else $error("command taken during forest sweep");

  a_stall_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    stat.init |-> in_stall)
    else $error("input transfer possible during forest sweep");
`endif

endmodule
